// File: hdl/rdd_pkg.sv
// types, constants and row helpers for the rrip/dip dead-block replacement block
// no dependencies
`timescale 1ns / 1ps
package rdd_pkg;
    localparam int NUM_SETS       = 2048;
    localparam int NUM_WAYS       = 16;
    localparam int NUM_LEADERS    = 64;
    localparam int SELECTOR_WIDTH = 10;

    localparam int SET_W    = $clog2(NUM_SETS);
    localparam int WAY_W    = 4;
    localparam int ROW_W    = NUM_WAYS * 4;
    localparam int LEAD_SH  = $clog2(NUM_SETS / NUM_LEADERS);
    localparam int CFG_W    = 17;

    localparam logic [SELECTOR_WIDTH-1:0] SEL_MAX = '1;
    localparam logic [SELECTOR_WIDTH-1:0] SEL_MID = SELECTOR_WIDTH'(1) << (SELECTOR_WIDTH - 1);
    localparam logic [1:0] RRPV_MAX     = 2'd3;
    localparam logic [1:0] RRPV_DISTANT = 2'd2;
    localparam logic [1:0] DEAD_MAX     = 2'd3;
    localparam logic [1:0] DEAD_NEUTRAL = 2'd1;

    localparam logic CFG_DECAY = 1'b0;
    localparam logic CFG_BIP   = 1'b1;
    localparam logic KIND_VICTIM = 1'b0;

    typedef logic [ROW_W-1:0] t_row;

    typedef struct packed {
        logic             kind;
        logic [WAY_W-1:0] way;
        logic [15:0]      valid_mask;
        logic             hit;
        logic [1:0]       ins_rrpv;
        logic             decay;
    } t_row_req;

    // way w: rrpv at [4w+3:4w+2], dead counter at [4w+1:4w]
    function automatic t_row init_row();
        t_row r;
        for (int w = 0; w < NUM_WAYS; w++) begin
            r[4*w +: 4] = {RRPV_DISTANT, DEAD_NEUTRAL};
        end
        return r;
    endfunction

    function automatic t_row decay_row(t_row a);
        t_row r;
        r = a;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (a[4*w +: 2] != 2'd0) begin
                r[4*w +: 2] = a[4*w +: 2] - 2'd1;
            end
        end
        return r;
    endfunction
endpackage

// File: hdl/rdd_row_calc.sv
// per-set row logic: victim search with aging, and hit/fill update of one way
// depends on rdd_pkg
`timescale 1ns / 1ps
module rdd_row_calc import rdd_pkg::*; (
    input  t_row             i_row,
    input  t_row_req         i_req,
    output t_row             o_row,
    output logic [WAY_W-1:0] o_victim
);
    logic [1:0] top;
    logic [1:0] age;
    logic       found_inv;
    logic       found_dead;
    logic [WAY_W-1:0] inv_way;
    logic [WAY_W-1:0] dead_way;
    logic [WAY_W-1:0] old_way;
    t_row aged;
    logic [1:0] dead_cur;

    always_comb begin
        top = 2'd0;
        found_inv = 1'b0;
        found_dead = 1'b0;
        inv_way = '0;
        dead_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (w < 16 && !i_req.valid_mask[w]) begin
                found_inv = 1'b1;
                inv_way = WAY_W'(w);
            end
            if (i_row[4*w +: 2] == 2'd0) begin
                found_dead = 1'b1;
                dead_way = WAY_W'(w);
            end
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (i_row[4*w+2 +: 2] > top) begin
                top = i_row[4*w+2 +: 2];
            end
        end
        age = RRPV_MAX - top;
        aged = i_row;
        old_way = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            aged[4*w+2 +: 2] = i_row[4*w+2 +: 2] + age;
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (aged[4*w+2 +: 2] == RRPV_MAX) begin
                old_way = WAY_W'(w);
            end
        end

        o_row = i_row;
        o_victim = old_way;
        dead_cur = i_row[4*i_req.way +: 2];
        if (i_req.kind == KIND_VICTIM) begin
            if (found_inv) begin
                o_victim = inv_way;
            end else if (found_dead) begin
                o_victim = dead_way;
            end else begin
                o_row = aged;
            end
        end else if (i_req.hit) begin
            o_row[4*i_req.way+2 +: 2] = 2'd0;
            o_row[4*i_req.way +: 2] = (dead_cur < DEAD_MAX) ? dead_cur + 2'd1 : dead_cur;
        end else begin
            // fill ahead of a decay sweep is stored one higher
            o_row[4*i_req.way+2 +: 2] = i_req.ins_rrpv;
            o_row[4*i_req.way +: 2] = i_req.decay ? DEAD_NEUTRAL + 2'd1 : DEAD_NEUTRAL;
        end
    end
endmodule

// File: hdl/rrip_dip_deadblock_replacement_top.sv
// top level: set-row memory, request sequencer, policy selector and decay sweeps
// depends on rdd_pkg and rdd_row_calc
`timescale 1ns / 1ps
// Replacement state for a 2048-set, 16-way cache, one 64-bit row per set in a
// single-port-read, single-port-write memory. The row of a request is read at
// acceptance and written back from the exec state, where a victim request also
// registers its result. A victim request stays in the exec state for as long as
// the previous result has not been taken. After reset a clearing pass
// initializes the memory before the first request is taken. An update that
// reaches the decay period starts a sweep that decrements every nonzero dead
// counter, one row per cycle, during which no request is taken.
// Configuration writes are taken at any time.
module rrip_dip_deadblock_replacement_top import rdd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_kind,
    input  logic [10:0]      i_set_index,
    input  logic [3:0]       i_way_index,
    input  logic [15:0]      i_valid_mask,
    input  logic             i_hit,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [3:0]       o_victim_way
);
    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_SWEEP = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [SET_W:0] r_cnt, n_cnt;
    logic [CFG_W-1:0] r_decay_period;
    logic [3:0] r_bip_log2;
    logic [SELECTOR_WIDTH-1:0] r_psel, n_psel;
    logic [15:0] r_upd_cnt, n_upd_cnt;
    logic [7:0] r_bip_cnt, n_bip_cnt;
    logic [15:0] r_lfsr, n_lfsr;
    logic r_kind, r_hit;
    logic [SET_W-1:0] r_set;
    logic [WAY_W-1:0] r_way;
    logic [15:0] r_vmask;
    logic r_out_valid, n_out_valid;
    logic [3:0] r_victim, n_victim;
    t_row r_rd_data;
    t_row mem [NUM_SETS];

    logic accept;
    logic [SET_W-1:0] rd_addr, wr_addr;
    logic we;
    t_row wr_data;
    t_row calc_row;
    logic [WAY_W-1:0] calc_victim;
    t_row_req req;
    logic [16:0] period, next_cnt;
    logic [3:0] l_clamp;
    logic [7:0] bmask;
    logic lip_lead, bip_lead, stall;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_victim_way = r_victim;

    rdd_row_calc u_calc (
        .i_row    (r_rd_data),
        .i_req    (req),
        .o_row    (calc_row),
        .o_victim (calc_victim)
    );

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        period = (r_decay_period == '0) ? 17'd1 :
                 (r_decay_period > 17'd65536) ? 17'd65536 : r_decay_period;
        next_cnt = {1'b0, r_upd_cnt} + 17'd1;
        l_clamp = (r_bip_log2 > 4'd8) ? 4'd8 : r_bip_log2;
        bmask = 8'((9'd1 << l_clamp) - 9'd1);
        lip_lead = (r_set[LEAD_SH-1:0] == '0) && (r_set < SET_W'(NUM_SETS / 2));
        bip_lead = (r_set[LEAD_SH-1:0] == '0) && !(r_set < SET_W'(NUM_SETS / 2));

        n_psel = r_psel;
        n_bip_cnt = r_bip_cnt;
        n_lfsr = r_lfsr;
        req.kind = r_kind;
        req.way = r_way;
        req.valid_mask = r_vmask;
        req.hit = r_hit;
        req.decay = (next_cnt >= period);
        req.ins_rrpv = 2'd0;
        if (lip_lead) begin
            if (r_psel < SEL_MAX) n_psel = r_psel + 1'b1;
        end else if (bip_lead) begin
            if (r_psel > '0) n_psel = r_psel - 1'b1;
            n_bip_cnt = r_bip_cnt + 8'd1;
            req.ins_rrpv = ((n_bip_cnt & bmask) == '0) ? 2'd0 : RRPV_DISTANT;
        end else if (r_psel < SEL_MID) begin
            n_lfsr = (r_lfsr >> 1) ^ (r_lfsr[0] ? 16'hB400 : 16'h0000);
            req.ins_rrpv = ((n_lfsr[7:0] & bmask) == '0) ? 2'd0 : RRPV_DISTANT;
        end

        stall = (r_kind == KIND_VICTIM) && r_out_valid && !i_out_ready;
        n_state = r_state;
        n_cnt = r_cnt;
        n_upd_cnt = r_upd_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_victim = r_victim;
        rd_addr = r_cnt[SET_W-1:0];
        wr_addr = r_cnt[SET_W-1:0];
        wr_data = init_row();
        we = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                we = (r_cnt < (SET_W+1)'(NUM_SETS));
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (SET_W+1)'(NUM_SETS)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                rd_addr = i_set_index;
                if (accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                rd_addr = r_set;
                wr_addr = r_set;
                wr_data = calc_row;
                if (!stall) begin
                    we = 1'b1;
                    n_state = ST_IDLE;
                    if (r_kind == KIND_VICTIM) begin
                        n_out_valid = 1'b1;
                        n_victim = calc_victim;
                    end else begin
                        if (req.decay) begin
                            n_upd_cnt = '0;
                            n_cnt = '0;
                            n_state = ST_SWEEP;
                        end else begin
                            n_upd_cnt = next_cnt[15:0];
                        end
                    end
                end
            end
            ST_SWEEP: begin
                wr_addr = SET_W'(r_cnt - 1'b1);
                wr_data = decay_row(r_rd_data);
                we = (r_cnt != '0);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (SET_W+1)'(NUM_SETS)) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt <= '0;
            r_decay_period <= 17'd32768;
            r_bip_log2 <= 4'd5;
            r_psel <= SEL_MID;
            r_upd_cnt <= '0;
            r_bip_cnt <= '0;
            r_lfsr <= 16'hACE1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_upd_cnt <= n_upd_cnt;
            r_out_valid <= n_out_valid;
            if (r_state == ST_EXEC && !stall && r_kind != KIND_VICTIM && !r_hit) begin
                r_psel <= n_psel;
                r_bip_cnt <= n_bip_cnt;
                r_lfsr <= n_lfsr;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DECAY: r_decay_period <= i_cfg_data;
                    CFG_BIP:   r_bip_log2 <= i_cfg_data[3:0];
                    default:   r_bip_log2 <= r_bip_log2;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_victim <= n_victim;
        if (accept) begin
            r_kind <= i_kind;
            r_set <= i_set_index;
            r_way <= i_way_index;
            r_vmask <= i_valid_mask;
            r_hit <= i_hit;
        end
    end

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_EXEC))
        else $error("accepted request did not enter exec");
    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_EXEC && !$past(r_kind)))
        else $error("result raised outside a victim exec");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !we)
        else $error("memory written while idle");
endmodule
